>>> rtl/dual_hysteresis_alarm_cooldown_top_macros.svh
// Assertion macros used by the alarm block's top-level RTL file.
`ifndef DUAL_HYSTERESIS_ALARM_COOLDOWN_TOP_MACROS_SVH
`define DUAL_HYSTERESIS_ALARM_COOLDOWN_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off during rst.
`define DHAC_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off during rst.
`define DHAC_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/dhac_pkg.sv
// Shared types and constants for the dual hysteresis alarm block.
package dhac_pkg;

  // Common signed width for limit and value comparisons, with room for margins.
  typedef logic signed [9:0] ext_t;

  // Beep pattern codes carried by each result.
  typedef enum logic [1:0] {
    BEEP_NONE = 2'd0,
    BEEP_BOTH = 2'd1,
    BEEP_TEMP = 2'd2,
    BEEP_HUMI = 2'd3
  } beep_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_TEMP_HIGH = 3'd0,
    REG_TEMP_LOW  = 3'd1,
    REG_TEMP_MARG = 3'd2,
    REG_HUMI_HIGH = 3'd3,
    REG_HUMI_LOW  = 3'd4,
    REG_HUMI_MARG = 3'd5,
    REG_COOLDOWN  = 3'd6
  } cfg_reg_t;

  // Register values after reset.
  localparam logic signed [7:0] TEMP_HIGH_RST = 8'sd35;
  localparam logic signed [7:0] TEMP_LOW_RST  = 8'sd24;
  localparam logic [5:0]        TEMP_MARG_RST = 6'd1;
  localparam logic [7:0]        HUMI_HIGH_RST = 8'd80;
  localparam logic [7:0]        HUMI_LOW_RST  = 8'd35;
  localparam logic [5:0]        HUMI_MARG_RST = 6'd3;
  localparam logic [31:0]       COOLDOWN_RST  = 32'd30000;

endpackage

>>> rtl/dhac_channel.sv
// One channel's hysteresis tracker: abnormal flag register and its update logic.
module dhac_channel (
  input  logic          clk,
  input  logic          rst,
  input  logic          update,
  input  dhac_pkg::ext_t value,
  input  dhac_pkg::ext_t high_limit,
  input  dhac_pkg::ext_t low_limit,
  input  logic [5:0]    margin,
  output logic          flag,
  output logic          flag_next
);

  dhac_pkg::ext_t margin_ext;
  dhac_pkg::ext_t clear_high;
  dhac_pkg::ext_t clear_low;
  logic           set_cond;
  logic           clear_cond;

  // Clear window is the limits pulled inwards by the margin, computed without wrap.
  assign margin_ext = $signed({4'b0000, margin});
  assign clear_high = high_limit - margin_ext;
  assign clear_low  = low_limit + margin_ext;

  // Set on reaching either limit; clear only inside the narrowed window.
  assign set_cond   = (value >= high_limit) || (value <= low_limit);
  assign clear_cond = (value <= clear_high) && (value >= clear_low);
  assign flag_next  = flag ? !clear_cond : set_cond;

  // Flag follows the sample that is being retired.
  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
    end else if (update) begin
      flag <= flag_next;
    end
  end

endmodule

>>> rtl/dual_hysteresis_alarm_cooldown_top.sv
// Top level of the dual-channel hysteresis alarm with cooldown.

// Takes one temperature/humidity sample per clock and returns one result per
// sample: both abnormal flags and a beep code (none, combined, temperature,
// humidity). A request is accepted when sample_valid is high and sample_stall is
// low. An accepted sample is held in the input register and moves on into the
// result register, which sets result_valid, once that register is empty or its
// result is being taken. A new sample is taken every cycle as long as the
// result side keeps up. All flag, window and cooldown logic is combinational
// between the input register and the result register, which loads together
// with the flags and the three time stamps. Configuration writes are always
// taken (cfg_ready is high), act at once, and writes to unknown indexes are
// dropped.
`include "dual_hysteresis_alarm_cooldown_top_macros.svh"

module dual_hysteresis_alarm_cooldown_top (
  input  logic               clk,
  input  logic               rst,
  // Sample channel
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic signed [7:0]  temperature,
  input  logic [7:0]         humidity,
  input  logic [31:0]        time_ms,
  // Result channel
  output logic               result_valid,
  input  logic               result_stall,
  output logic               temp_abnormal,
  output logic               humi_abnormal,
  output logic [1:0]         beep_code,
  // Configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  // Configuration registers
  logic signed [7:0] temp_high_limit;
  logic signed [7:0] temp_low_limit;
  logic [5:0]        temp_margin;
  logic [7:0]        humi_high_limit;
  logic [7:0]        humi_low_limit;
  logic [5:0]        humi_margin;
  logic [31:0]       cooldown_ms;

  // Input register
  logic              s1_valid;
  logic signed [7:0] temperature_q;
  logic [7:0]        humidity_q;
  logic [31:0]       time_q;

  // State
  logic              temp_flag;
  logic              humi_flag;
  logic              temp_flag_next;
  logic              humi_flag_next;
  logic [31:0]       temp_stamp;
  logic [31:0]       humi_stamp;
  logic [31:0]       both_stamp;

  logic              sample_accept;
  logic              s1_move;
  logic              temp_due;
  logic              humi_due;
  logic              both_due;
  dhac_pkg::beep_t   code_next;

  // Configuration port never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_high_limit <= dhac_pkg::TEMP_HIGH_RST;
      temp_low_limit  <= dhac_pkg::TEMP_LOW_RST;
      temp_margin     <= dhac_pkg::TEMP_MARG_RST;
      humi_high_limit <= dhac_pkg::HUMI_HIGH_RST;
      humi_low_limit  <= dhac_pkg::HUMI_LOW_RST;
      humi_margin     <= dhac_pkg::HUMI_MARG_RST;
      cooldown_ms     <= dhac_pkg::COOLDOWN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (dhac_pkg::cfg_reg_t'(cfg_index))
        dhac_pkg::REG_TEMP_HIGH: temp_high_limit <= $signed(cfg_data[7:0]);
        dhac_pkg::REG_TEMP_LOW:  temp_low_limit  <= $signed(cfg_data[7:0]);
        dhac_pkg::REG_TEMP_MARG: temp_margin     <= cfg_data[5:0];
        dhac_pkg::REG_HUMI_HIGH: humi_high_limit <= cfg_data[7:0];
        dhac_pkg::REG_HUMI_LOW:  humi_low_limit  <= cfg_data[7:0];
        dhac_pkg::REG_HUMI_MARG: humi_margin     <= cfg_data[5:0];
        dhac_pkg::REG_COOLDOWN:  cooldown_ms     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Handshake: the input register empties whenever the result register can take it.
  assign s1_move       = s1_valid && (!result_valid || !result_stall);
  assign sample_stall  = s1_valid && !s1_move;
  assign sample_accept = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_accept) begin
      temperature_q <= temperature;
      humidity_q    <= humidity;
      time_q        <= time_ms;
    end
  end

  // Channel trackers
  dhac_channel u_temp (
    .clk        (clk),
    .rst        (rst),
    .update     (s1_move),
    .value      ($signed({{2{temperature_q[7]}}, temperature_q})),
    .high_limit ($signed({{2{temp_high_limit[7]}}, temp_high_limit})),
    .low_limit  ($signed({{2{temp_low_limit[7]}}, temp_low_limit})),
    .margin     (temp_margin),
    .flag       (temp_flag),
    .flag_next  (temp_flag_next)
  );

  dhac_channel u_humi (
    .clk        (clk),
    .rst        (rst),
    .update     (s1_move),
    .value      ($signed({2'b00, humidity_q})),
    .high_limit ($signed({2'b00, humi_high_limit})),
    .low_limit  ($signed({2'b00, humi_low_limit})),
    .margin     (humi_margin),
    .flag       (humi_flag),
    .flag_next  (humi_flag_next)
  );

  // Cooldown checks with wrapping time differences.
  assign both_due = (32'(time_q - both_stamp) >= cooldown_ms);
  assign temp_due = (32'(time_q - temp_stamp) >= cooldown_ms);
  assign humi_due = (32'(time_q - humi_stamp) >= cooldown_ms);

  // Beep selection: combined alarm takes priority over single channels.
  always_comb begin
    code_next = dhac_pkg::BEEP_NONE;
    priority if (temp_flag_next && humi_flag_next) begin
      if (both_due) code_next = dhac_pkg::BEEP_BOTH;
    end else if (temp_flag_next) begin
      if (temp_due) code_next = dhac_pkg::BEEP_TEMP;
    end else if (humi_flag_next) begin
      if (humi_due) code_next = dhac_pkg::BEEP_HUMI;
    end else begin
      code_next = dhac_pkg::BEEP_NONE;
    end
  end

  // Stamp updates on the retiring sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_stamp <= '0;
      humi_stamp <= '0;
      both_stamp <= '0;
    end else if (s1_move) begin
      unique case (code_next)
        dhac_pkg::BEEP_BOTH: begin
          both_stamp <= time_q;
          temp_stamp <= time_q;
          humi_stamp <= time_q;
        end
        dhac_pkg::BEEP_TEMP: temp_stamp <= time_q;
        dhac_pkg::BEEP_HUMI: humi_stamp <= time_q;
        default: begin
        end
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_move) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      temp_abnormal <= temp_flag_next;
      humi_abnormal <= humi_flag_next;
      beep_code     <= code_next;
    end
  end

  // A combined alarm is only ever reported with both flags set.
  `DHAC_ASSERT_NOW(a_both_flags,
    result_valid && beep_code == 2'(dhac_pkg::BEEP_BOTH),
    temp_abnormal && humi_abnormal, "combined alarm without both flags")
  // A temperature alarm means the temperature channel alone is abnormal.
  `DHAC_ASSERT_NOW(a_temp_only,
    result_valid && beep_code == 2'(dhac_pkg::BEEP_TEMP),
    temp_abnormal && !humi_abnormal, "temperature alarm with wrong flags")
  // After a combined alarm all three stamps agree.
  `DHAC_ASSERT_NEXT(a_stamps_sync, s1_move && code_next == dhac_pkg::BEEP_BOTH,
    both_stamp == temp_stamp && temp_stamp == humi_stamp,
    "stamps differ after combined alarm")
  // An accepted sample always lands in the input register.
  `DHAC_ASSERT_NEXT(a_accept_held, sample_accept, s1_valid, "accepted sample lost")
  // The flags seen on a result are the tracked state after that sample.
  `DHAC_ASSERT_NEXT(a_flag_match, s1_move,
    temp_abnormal == temp_flag && humi_abnormal == humi_flag,
    "result flags differ from state")

endmodule
